/* sv/byte_stuffed_frame_receiver_top_assert.svh */
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_top_assert.svh
// Assertion macros used by the frame receiver top.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Clocked check, off while reset is asserted
`define BSFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset
`define BSFR_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/bsfr_pkg.sv */
// ----------------------------------------------------------------------------
// bsfr_pkg
// Types and constants shared by the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 11;
  localparam int unsigned KindW  = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned RegIdxW = 3;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_DATA     = 2'd0,
    KIND_END      = 2'd1,
    KIND_OVERFLOW = 2'd2,
    KIND_ABORT    = 2'd3
  } kind_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [RegIdxW-1:0] REG_START_DELIM = 3'd0;
  localparam logic [RegIdxW-1:0] REG_ESCAPE_CODE = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ABORT_CODE  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_XOR_MASK    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_MAX_LEN     = 3'd4;

  // Register reset values
  localparam logic [ByteW-1:0] RST_START_DELIM = 8'd126;
  localparam logic [ByteW-1:0] RST_ESCAPE_CODE = 8'd125;
  localparam logic [ByteW-1:0] RST_ABORT_CODE  = 8'd127;
  localparam logic [ByteW-1:0] RST_XOR_MASK    = 8'd32;
  localparam logic [LenW-1:0]  RST_MAX_LEN     = 11'd1024;

  typedef struct packed {
    logic [ByteW-1:0] start_delim;
    logic [ByteW-1:0] escape_code;
    logic [ByteW-1:0] abort_code;
    logic [ByteW-1:0] xor_mask;
    logic [LenW-1:0]  max_len;
  } cfg_t;

  typedef struct packed {
    logic            in_frame;
    logic            escape_pending;
    logic [LenW-1:0] byte_count;
  } state_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic [ByteW-1:0] payload;
    logic [LenW-1:0]  frame_len;
  } result_t;

endpackage

/* sv/byte_stuffed_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_top
// Deframes a byte-stuffed link stream into payload, end, abort and overflow
// words.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in_     | input     | in_valid/in_ready  | rx_byte
//   out_    | output    | out_valid/out_ready| kind, payload, frame_len
//   cfg_    | input     | APB write/read     | five 32-bit registers
//
// One word enters per cycle while the result is not stalled; results are registered.
// The rate is set by the single decode stage between the input register and
// the result register, with frame state updated as a word leaves the input
// register. A stalled result holds the input register; in_ready follows
// out_ready in the same cycle. Reset clears frame state and both valid flags.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_receiver_top_assert.svh"

module byte_stuffed_frame_receiver_top #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_payload,
  output logic [10:0]                     out_frame_len,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bsfr_pkg::AddrW-1:0]      cfg_paddr,
  input  logic [bsfr_pkg::DataW-1:0]      cfg_pwdata,
  output logic [bsfr_pkg::DataW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import bsfr_pkg::*;

  cfg_t             cfg;
  state_t           state_r;
  state_t           state_nxt;
  result_t          res;
  result_t          res_r;
  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_adv;

  bsfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bsfr_decode #(
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .cfg     (cfg),
    .st      (state_r),
    .rx_byte (s1_byte_r),
    .st_nxt  (state_nxt),
    .res     (res)
  );

  // Advance the input word when the result slot is free or draining
  assign s1_adv   = s1_valid_r & (~res_r.valid | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.valid <= 1'b0;
    end else if (s1_adv) begin
      res_r.valid <= res.valid;
    end else if (out_ready) begin
      res_r.valid <= 1'b0;
    end
    if (s1_adv) begin
      res_r.kind      <= res.kind;
      res_r.payload   <= res.payload;
      res_r.frame_len <= res.frame_len;
    end
  end

  assign out_valid     = res_r.valid;
  assign out_kind      = res_r.kind;
  assign out_payload   = res_r.payload;
  assign out_frame_len = res_r.frame_len;

  `BSFR_ASSERT(a_idle_clean, !state_r.in_frame |-> (state_r.byte_count == '0 && !state_r.escape_pending), "state left over outside a frame")
  `BSFR_ASSERT(a_count_bound, 17'(state_r.byte_count) <= 17'(MAX_FRAME), "byte count beyond frame limit")
  `BSFR_ASSERT(a_end_nonempty, (res_r.valid && res_r.kind == KIND_END) |-> res_r.frame_len != '0, "empty frame reported")
  `BSFR_ASSERT(a_hold_input, (s1_valid_r && res_r.valid && !out_ready) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(state_r)), "input word lost while result stalled")
  `BSFR_ASSERT_RST(a_reset_clear, !rst_n |=> (!res_r.valid && !s1_valid_r && !state_r.in_frame), "valid flags not cleared by reset")

endmodule

/* sv/bsfr_cfg.sv */
// ----------------------------------------------------------------------------
// bsfr_cfg
// APB-style register file holding the framing codes and the length limit.
// ----------------------------------------------------------------------------
module bsfr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsfr_pkg::AddrW-1:0]      paddr,
  input  logic [bsfr_pkg::DataW-1:0]      pwdata,
  output logic [bsfr_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  output bsfr_pkg::cfg_t                  cfg
);
  import bsfr_pkg::*;

  cfg_t               cfg_r;
  cfg_t               cfg_nxt;
  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START_DELIM: cfg_nxt.start_delim = pwdata[ByteW-1:0];
        REG_ESCAPE_CODE: cfg_nxt.escape_code = pwdata[ByteW-1:0];
        REG_ABORT_CODE:  cfg_nxt.abort_code  = pwdata[ByteW-1:0];
        REG_XOR_MASK:    cfg_nxt.xor_mask    = pwdata[ByteW-1:0];
        REG_MAX_LEN:     cfg_nxt.max_len     = pwdata[LenW-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delim <= RST_START_DELIM;
      cfg_r.escape_code <= RST_ESCAPE_CODE;
      cfg_r.abort_code  <= RST_ABORT_CODE;
      cfg_r.xor_mask    <= RST_XOR_MASK;
      cfg_r.max_len     <= RST_MAX_LEN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_START_DELIM: prdata = {(DataW-ByteW)'(0), cfg_r.start_delim};
      REG_ESCAPE_CODE: prdata = {(DataW-ByteW)'(0), cfg_r.escape_code};
      REG_ABORT_CODE:  prdata = {(DataW-ByteW)'(0), cfg_r.abort_code};
      REG_XOR_MASK:    prdata = {(DataW-ByteW)'(0), cfg_r.xor_mask};
      REG_MAX_LEN:     prdata = {(DataW-LenW)'(0), cfg_r.max_len};
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

/* sv/bsfr_decode.sv */
// ----------------------------------------------------------------------------
// bsfr_decode
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module bsfr_decode #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  bsfr_pkg::cfg_t                 cfg,
  input  bsfr_pkg::state_t               st,
  input  logic [bsfr_pkg::ByteW-1:0]     rx_byte,
  output bsfr_pkg::state_t               st_nxt,
  output bsfr_pkg::result_t              res
);
  import bsfr_pkg::*;

  localparam int unsigned CmpW = 17;

  logic             clamp;
  logic [LenW-1:0]  limit;
  logic [ByteW-1:0] data_byte;

  // Clamp the programmed limit to the build-time maximum
  assign clamp = CmpW'(MAX_FRAME) < {(CmpW-LenW)'(0), cfg.max_len};
  assign limit = clamp ? LenW'(MAX_FRAME) : cfg.max_len;

  // Undo the escape
  assign data_byte = st.escape_pending ? (rx_byte ^ cfg.xor_mask) : rx_byte;

  always_comb begin
    st_nxt        = st;
    res.valid     = 1'b0;
    res.kind      = KIND_DATA;
    res.payload   = '0;
    res.frame_len = '0;
    if (rx_byte == cfg.start_delim) begin
      // Open, close, or skip an empty frame
      if (!st.in_frame) begin
        st_nxt.in_frame = 1'b1;
      end else if (st.byte_count != '0) begin
        res.valid     = 1'b1;
        res.kind      = KIND_END;
        res.frame_len = st.byte_count;
        st_nxt        = '0;
      end
    end else if (st.in_frame) begin
      if (rx_byte == cfg.abort_code) begin
        res.valid             = 1'b1;
        res.kind              = KIND_ABORT;
        st_nxt.byte_count     = '0;
        st_nxt.escape_pending = 1'b0;
      end else if (rx_byte == cfg.escape_code) begin
        st_nxt.escape_pending = 1'b1;
      end else if (st.byte_count < limit) begin
        res.valid             = 1'b1;
        res.payload           = data_byte;
        st_nxt.escape_pending = 1'b0;
        st_nxt.byte_count     = st.byte_count + LenW'(1);
      end else begin
        // Drop the byte and go idle
        res.valid = 1'b1;
        res.kind  = KIND_OVERFLOW;
        st_nxt    = '0;
      end
    end
  end

endmodule
